[rtl/plex_pkg.sv]
`default_nettype none

package plex_pkg;

    localparam int POS_W  = 24;
    localparam int KIND_W = 5;
    localparam int LEN_W  = 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_BANG  = 5'd11;
    localparam logic [KIND_W-1:0] KIND_ERROR = 5'd19;
    localparam logic [KIND_W-1:0] KIND_EOF   = 5'd20;

    localparam logic [LEN_W-1:0] LEN_NONE = 2'd0;
    localparam logic [LEN_W-1:0] LEN_ONE  = 2'd1;
    localparam logic [LEN_W-1:0] LEN_TWO  = 2'd2;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_EQ  = 8'h3D;

    typedef enum logic [1:0] {
        HOLD_BANG = 2'd0,
        HOLD_EQ   = 2'd1,
        HOLD_GT   = 2'd2,
        HOLD_LT   = 2'd3
    } t_hold;

    typedef enum logic [2:0] {
        CLS_SKIP,
        CLS_NEWLINE,
        CLS_SINGLE,
        CLS_HOLD,
        CLS_ERROR
    } t_cls;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  offset;
        logic [LEN_W-1:0]  length;
        logic [POS_W-1:0]  line;
        logic              last;
    } t_token;

    function automatic t_cls char_class(input logic [7:0] c);
        t_cls cls;
        case (c) inside
            CH_SP, CH_TAB, CH_CR: cls = CLS_SKIP;
            CH_LF: cls = CLS_NEWLINE;
            "(", ")", "{", "}", ",", ".", "-", "+", ";", "/", "*": cls = CLS_SINGLE;
            "!", "=", ">", "<": cls = CLS_HOLD;
            default: cls = CLS_ERROR;
        endcase
        return cls;
    endfunction

    function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            "(": k = 5'd0;
            ")": k = 5'd1;
            "{": k = 5'd2;
            "}": k = 5'd3;
            ",": k = 5'd4;
            ".": k = 5'd5;
            "-": k = 5'd6;
            "+": k = 5'd7;
            ";": k = 5'd8;
            "/": k = 5'd9;
            "*": k = 5'd10;
            default: k = KIND_ERROR;
        endcase
        return k;
    endfunction

    function automatic t_hold hold_code(input logic [7:0] c);
        t_hold h;
        case (c)
            "=": h = HOLD_EQ;
            ">": h = HOLD_GT;
            "<": h = HOLD_LT;
            default: h = HOLD_BANG;
        endcase
        return h;
    endfunction

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
        return (&v) ? v : v + POS_W'(1);
    endfunction

endpackage

`default_nettype wire

[rtl/plex_scan.sv]
`default_nettype none

module plex_scan
    import plex_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_src_byte,
    input  wire logic       i_end_mark,
    output t_token          o_tok0,
    output t_token          o_tok1,
    output logic [1:0]      o_count
);

    logic             r_pend;
    t_hold            r_which;
    logic [POS_W-1:0] r_pend_off;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_line;

    logic             n_pend;
    t_hold            n_which;
    logic [POS_W-1:0] n_pend_off;
    logic [POS_W-1:0] n_pos;
    logic [POS_W-1:0] n_line;

    logic              is_end;
    t_cls              cls;
    logic [KIND_W-1:0] pend_kind;
    t_token            pend_tok;
    t_token            cur_tok;
    t_token            eof_tok;
    logic              emit_cur;

    always_comb begin
        is_end    = i_end_mark || (i_src_byte == CH_NUL);
        cls       = char_class(i_src_byte);
        pend_kind = KIND_BANG + {2'b00, r_which, 1'b0};
        emit_cur  = (cls == CLS_SINGLE) || (cls == CLS_ERROR);

        pend_tok = '{kind: pend_kind, offset: r_pend_off, length: LEN_ONE,
                     line: r_line, last: 1'b0};
        cur_tok  = '{kind: (cls == CLS_SINGLE) ? single_kind(i_src_byte) : KIND_ERROR,
                     offset: r_pos, length: LEN_ONE, line: r_line, last: 1'b1};
        eof_tok  = '{kind: KIND_EOF, offset: r_pos, length: LEN_NONE,
                     line: r_line, last: 1'b1};

        n_pend     = r_pend;
        n_which    = r_which;
        n_pend_off = r_pend_off;
        n_pos      = sat_inc(r_pos);
        n_line     = r_line;
        o_tok0     = pend_tok;
        o_tok1     = cur_tok;
        o_count    = 2'd0;

        if (is_end) begin
            n_pend     = 1'b0;
            n_which    = HOLD_BANG;
            n_pend_off = '0;
            n_pos      = '0;
            n_line     = POS_W'(1);
            o_tok1     = eof_tok;
            if (r_pend) begin
                o_count = 2'd2;
            end else begin
                o_tok0  = eof_tok;
                o_count = 2'd1;
            end
        end else if (r_pend && (i_src_byte == CH_EQ)) begin
            n_pend      = 1'b0;
            o_tok0.kind = pend_kind + KIND_W'(1);
            o_tok0.length = LEN_TWO;
            o_tok0.last = 1'b1;
            o_count     = 2'd1;
        end else begin
            n_pend  = 1'b0;
            o_count = {1'b0, r_pend} + {1'b0, emit_cur};
            if (!r_pend) begin
                o_tok0 = cur_tok;
            end else if (!emit_cur) begin
                o_tok0.last = 1'b1;
            end
            case (cls)
                CLS_NEWLINE: begin
                    n_line = sat_inc(r_line);
                end
                CLS_HOLD: begin
                    n_pend     = 1'b1;
                    n_which    = hold_code(i_src_byte);
                    n_pend_off = r_pos;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend     <= 1'b0;
            r_which    <= HOLD_BANG;
            r_pend_off <= '0;
            r_pos      <= '0;
            r_line     <= POS_W'(1);
        end else if (i_fire) begin
            r_pend     <= n_pend;
            r_which    <= n_which;
            r_pend_off <= n_pend_off;
            r_pos      <= n_pos;
            r_line     <= n_line;
        end
    end

endmodule

`default_nettype wire

[rtl/plex_tok_fifo.sv]
`default_nettype none

module plex_tok_fifo
    import plex_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [1:0] i_push_cnt,
    input  wire t_token     i_tok0,
    input  wire t_token     i_tok1,
    output logic            o_room2,
    output logic            o_valid,
    output t_token          o_tok,
    input  wire logic       i_pop
);

    t_token               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr;
    logic [FIFO_AW-1:0]   r_rd;
    logic [FIFO_CW-1:0]   r_cnt;
    logic [FIFO_CW-1:0]   n_cnt;
    logic                 pop;

    always_comb begin
        pop     = i_pop && (r_cnt != '0);
        n_cnt   = r_cnt + FIFO_CW'(i_push_cnt) - FIFO_CW'(pop);
        o_room2 = (r_cnt <= FIFO_CW'(FIFO_DEPTH - 2));
        o_valid = (r_cnt != '0);
        o_tok   = r_mem[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_tok0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wr + FIFO_AW'(1)] <= i_tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + FIFO_AW'(i_push_cnt);
            r_rd  <= r_rd + FIFO_AW'(pop);
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

[rtl/punctuation_operator_lexer_core.sv]
`default_nettype none

// Byte-at-a-time lexer for punctuation and comparison operators. One source byte
// is accepted per cycle into an input register while o_stall is low, is decoded
// from that register and its zero, one or two tokens are written to a four-entry
// token queue that drives the output ports. A byte is decoded only when the queue
// has room for two tokens, so with a free-running consumer the block sustains one
// byte per clock; bytes that produce two tokens drain at one token per cycle, and
// the output rate of one token per cycle is what limits throughput then. An end
// beat or a zero byte flushes any held operator, emits an end-of-file token
// and returns the offset and line counters to their reset values.
module punctuation_operator_lexer_core
    import plex_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [7:0]        i_src_byte,
    input  wire logic              i_end_mark,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [KIND_W-1:0]      o_token_kind,
    output logic [POS_W-1:0]       o_token_offset,
    output logic [LEN_W-1:0]       o_token_length,
    output logic [POS_W-1:0]       o_token_line,
    output logic                   o_last_of_run
);

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_end;
    logic       fire;
    logic       room2;
    logic [1:0] scan_cnt;
    logic [1:0] push_cnt;
    t_token     tok0;
    t_token     tok1;
    t_token     out_tok;

    assign fire     = r_in_valid && room2;
    assign o_stall  = r_in_valid && !room2;
    assign push_cnt = fire ? scan_cnt : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_byte <= i_src_byte;
            r_end  <= i_end_mark;
        end
    end

    plex_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_src_byte (r_byte),
        .i_end_mark (r_end),
        .o_tok0     (tok0),
        .o_tok1     (tok1),
        .o_count    (scan_cnt)
    );

    plex_tok_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_tok0     (tok0),
        .i_tok1     (tok1),
        .o_room2    (room2),
        .o_valid    (o_valid),
        .o_tok      (out_tok),
        .i_pop      (!i_stall)
    );

    assign o_token_kind   = out_tok.kind;
    assign o_token_offset = out_tok.offset;
    assign o_token_length = out_tok.length;
    assign o_token_line   = out_tok.line;
    assign o_last_of_run  = out_tok.last;

endmodule

`default_nettype wire
